[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL that checks itself.
// Needs nothing else; the enabled forms use concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");
`else
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/pipt_pkg.sv]
// Shared types and constants for the point-in-primitive test.
// Depends on nothing; used by the front, the queue, the back and the top level.
`default_nettype none
package pipt_pkg;

    // Primitive kinds as carried on the func field.
    typedef enum logic [1:0] {
        KIND_SPHERE   = 2'd0,
        KIND_PLANE    = 2'd1,
        KIND_CYLINDER = 2'd2
    } kind_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_QUERY_X = 2'd0;
    localparam logic [1:0] REG_QUERY_Y = 2'd1;
    localparam logic [1:0] REG_QUERY_Z = 2'd2;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // One classified primitive as it waits in the queue.
    typedef struct packed {
        kind_t              kind;
        logic               known;
        logic signed [32:0] wx;
        logic signed [32:0] wy;
        logic signed [32:0] wz;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic [30:0]        diam;
        logic [30:0]        len;
    } qent_t;

    // Queue status seen by the top level.
    typedef struct packed {
        logic [QCNT_W-1:0] count;
    } qstat_t;

    // Back pipeline status seen by the top level.
    typedef struct packed {
        logic adv;
        logic busy;
    } bstat_t;

endpackage
`default_nettype wire

[rtl/core/pipt_front.sv]
// Front part: holds the query point, accepts beats and classifies them.
// Depends on pipt_pkg for the queue entry type and register indexes.
`default_nettype none
module pipt_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 cfg_we,
    input  wire  [1:0]          cfg_addr,
    input  wire  [31:0]         cfg_wdata,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire  [1:0]          func,
    input  wire  signed [31:0]  anchor_x,
    input  wire  signed [31:0]  anchor_y,
    input  wire  signed [31:0]  anchor_z,
    input  wire  signed [31:0]  dir_x,
    input  wire  signed [31:0]  dir_y,
    input  wire  signed [31:0]  dir_z,
    input  wire  [30:0]         diameter,
    input  wire  [30:0]         length,
    output logic                push_valid,
    input  wire                 push_ready,
    output pipt_pkg::qent_t     push_data
);

    logic signed [31:0] qx_reg;
    logic signed [31:0] qy_reg;
    logic signed [31:0] qz_reg;
    logic               vld_reg;
    pipt_pkg::qent_t    ent_reg;
    pipt_pkg::qent_t    ent_next;

    // Query point registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qx_reg <= '0;
            qy_reg <= '0;
            qz_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                pipt_pkg::REG_QUERY_X: qx_reg <= $signed(cfg_wdata);
                pipt_pkg::REG_QUERY_Y: qy_reg <= $signed(cfg_wdata);
                pipt_pkg::REG_QUERY_Z: qz_reg <= $signed(cfg_wdata);
                default: ;
            endcase
        end
    end

    // Classify the kind and form the offset from the anchor to the query point.
    always_comb
    begin
        ent_next       = '0;
        ent_next.known = 1'b1;
        case (func)
            pipt_pkg::KIND_SPHERE:   ent_next.kind = pipt_pkg::KIND_SPHERE;
            pipt_pkg::KIND_PLANE:    ent_next.kind = pipt_pkg::KIND_PLANE;
            pipt_pkg::KIND_CYLINDER: ent_next.kind = pipt_pkg::KIND_CYLINDER;
            default:
            begin
                ent_next.kind  = pipt_pkg::KIND_SPHERE;
                ent_next.known = 1'b0;
            end
        endcase
        ent_next.wx   = 33'(qx_reg) - 33'(anchor_x);
        ent_next.wy   = 33'(qy_reg) - 33'(anchor_y);
        ent_next.wz   = 33'(qz_reg) - 33'(anchor_z);
        ent_next.ax   = dir_x;
        ent_next.ay   = dir_y;
        ent_next.az   = dir_z;
        ent_next.diam = diameter;
        ent_next.len  = length;
    end

    // One-entry holding register in front of the queue.
    assign in_ready   = !vld_reg || push_ready;
    assign push_valid = vld_reg;
    assign push_data  = ent_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            vld_reg <= 1'b1;
        end
        else if (push_ready)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            ent_reg <= ent_next;
        end
    end

endmodule
`default_nettype wire

[rtl/core/pipt_queue.sv]
// Short queue that decouples the front from the back pipeline.
// Depends on pipt_pkg for the entry type, depth and status struct.
`default_nettype none
module pipt_queue (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 push_valid,
    output logic                push_ready,
    input  wire  pipt_pkg::qent_t push_data,
    output logic                pop_valid,
    input  wire                 pop_ready,
    output pipt_pkg::qent_t     pop_data,
    output pipt_pkg::qstat_t    stat
);

    localparam int PW = $clog2(pipt_pkg::QUEUE_DEPTH);

    pipt_pkg::qent_t               mem [pipt_pkg::QUEUE_DEPTH];
    logic [PW-1:0]                 wr_reg;
    logic [PW-1:0]                 rd_reg;
    logic [pipt_pkg::QCNT_W-1:0]   cnt_reg;
    logic                          do_push;
    logic                          do_pop;

    assign push_ready = (cnt_reg != pipt_pkg::QCNT_W'(pipt_pkg::QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_data   = mem[rd_reg];
    assign stat.count = cnt_reg;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_reg <= (wr_reg == PW'(pipt_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_reg <= (rd_reg == PW'(pipt_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

[rtl/core/pipt_back.sv]
// Back part: thirteen-stage pipeline that evaluates the containment test.
// Depends on pipt_pkg; the last stage is the output register.
`default_nettype none
module pipt_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  q_valid,
    output logic                 q_ready,
    input  wire  pipt_pkg::qent_t q_data,
    output logic                 out_valid,
    input  wire                  out_ready,
    output logic                 inside_res,
    output pipt_pkg::bstat_t     stat
);

    localparam int F    = FRAC_BITS;
    localparam int VW   = (F + 35 > 64) ? F + 35 : 64;
    localparam int TW   = VW + 34;
    localparam int RW   = VW + 2;
    localparam int QRW  = RW - F - 1;
    localparam int HLW  = (QRW + 1) / 2;
    localparam int HHW  = QRW - HLW;
    localparam int SQW  = 2 * QRW;
    localparam int SSW  = SQW + 2;
    localparam int CW   = SSW + 3;
    localparam int NST  = 13;

    typedef struct packed {
        pipt_pkg::kind_t kind;
        logic            known;
        logic [61:0]     dsq;
        logic            simple_ok;
        logic            inrange;
    } ctx_t;

    logic                 adv;
    logic [NST:1]         vld_reg;
    ctx_t                 ctx_reg [1:NST-1];
    logic                 res_reg;

    logic signed [32:0]   w_in [3];
    logic signed [31:0]   a_in [3];

    logic signed [31:0]   a_reg [1:6][3];
    logic [30:0]          h_reg [1:5];
    logic signed [VW-1:0] v_reg [2:7][3];

    logic signed [32:0]   w1_reg [3];
    logic signed [63:0]   ah1_reg [3];
    logic [65:0]          wsq1_reg [3];
    logic signed [64:0]   aw1_reg [3];
    logic [67:0]          ssum2_reg;
    logic signed [66:0]   psum2_reg;
    logic signed [VW-1:0] pl3_reg [3];
    logic signed [64:0]   pp3_reg [3];
    logic signed [TW-1:0] tc4_reg [3];
    logic signed [TW-1:0] t5_reg;
    logic [31:0]          tq6_reg;
    logic signed [63:0]   m7_reg [3];
    logic signed [QRW-1:0] rq8_reg [3];
    logic [HHW-1:0]       hi9_reg [3];
    logic [HLW-1:0]       lo9_reg [3];
    logic [2*HHW-1:0]     hh10_reg [3];
    logic [QRW-1:0]       hl10_reg [3];
    logic [2*HLW-1:0]     ll10_reg [3];
    logic [SQW-1:0]       sq11_reg [3];
    logic [SSW-1:0]       s12_reg;

    logic signed [RW-1:0] r_c [3];
    logic [QRW-1:0]       mag_c [3];
    logic signed [TW-1:0] lim_c;
    logic                 sph_ok_c;
    logic                 pln_ok_c;
    logic                 cyl_ok_c;
    ctx_t                 ctx1_c;
    ctx_t                 ctx3_c;
    ctx_t                 ctx6_c;

    // The whole pipeline moves unless a finished result is waiting.
    assign adv        = !vld_reg[NST] || out_ready;
    assign q_ready    = adv;
    assign out_valid  = vld_reg[NST];
    assign inside_res = res_reg;
    assign stat.adv   = adv;
    assign stat.busy  = |vld_reg[NST-1:1];

    assign w_in[0] = q_data.wx;
    assign w_in[1] = q_data.wy;
    assign w_in[2] = q_data.wz;
    assign a_in[0] = q_data.ax;
    assign a_in[1] = q_data.ay;
    assign a_in[2] = q_data.az;

    // Combinational pieces that sit in front of individual stages.
    always_comb
    begin
        ctx1_c           = '0;
        ctx1_c.kind      = q_data.kind;
        ctx1_c.known     = q_data.known;
        ctx1_c.dsq       = 62'(q_data.diam) * 62'(q_data.diam);

        sph_ok_c = (72'(ctx_reg[2].dsq) >= 72'({ssum2_reg, 2'b00}));
        pln_ok_c = (psum2_reg == '0);
        ctx3_c   = ctx_reg[2];
        case (ctx_reg[2].kind)
            pipt_pkg::KIND_SPHERE:   ctx3_c.simple_ok = ctx_reg[2].known && sph_ok_c;
            pipt_pkg::KIND_PLANE:    ctx3_c.simple_ok = ctx_reg[2].known && pln_ok_c;
            default:                 ctx3_c.simple_ok = 1'b0;
        endcase

        lim_c  = TW'($signed({1'b0, h_reg[5]})) <<< (2 * F + 1);
        ctx6_c = ctx_reg[5];
        ctx6_c.inrange = !t5_reg[TW-1] && !(lim_c < t5_reg);

        for (int i = 0; i < 3; i++)
        begin
            r_c[i]   = RW'(v_reg[7][i]) - (RW'(m7_reg[i]) <<< 1);
            mag_c[i] = rq8_reg[i][QRW-1] ? QRW'(-rq8_reg[i]) : rq8_reg[i];
        end

        cyl_ok_c = ctx_reg[12].inrange && (CW'(ctx_reg[12].dsq) >= (CW'(s12_reg) << 2));
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NST-1:1], q_valid};
        end
    end

    // Datapath stages.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Stage 1: first products.
            ctx_reg[1] <= ctx1_c;
            a_reg[1]   <= a_in;
            h_reg[1]   <= q_data.len;
            for (int i = 0; i < 3; i++)
            begin
                w1_reg[i]   <= w_in[i];
                ah1_reg[i]  <= a_in[i] * $signed({1'b0, q_data.len});
                wsq1_reg[i] <= w_in[i] * w_in[i];
                aw1_reg[i]  <= a_in[i] * w_in[i];
            end

            // Stage 2: offset from the base cap, sphere and plane sums.
            ctx_reg[2] <= ctx_reg[1];
            a_reg[2]   <= a_reg[1];
            h_reg[2]   <= h_reg[1];
            for (int i = 0; i < 3; i++)
            begin
                v_reg[2][i] <= (VW'(w1_reg[i]) <<< (F + 1)) + VW'(ah1_reg[i]);
            end
            ssum2_reg <= 68'(wsq1_reg[0]) + 68'(wsq1_reg[1]) + 68'(wsq1_reg[2]);
            psum2_reg <= 67'(aw1_reg[0]) + 67'(aw1_reg[1]) + 67'(aw1_reg[2]);

            // Stage 3: sphere and plane verdicts, axis products in two halves.
            ctx_reg[3] <= ctx3_c;
            a_reg[3]   <= a_reg[2];
            h_reg[3]   <= h_reg[2];
            v_reg[3]   <= v_reg[2];
            for (int i = 0; i < 3; i++)
            begin
                pl3_reg[i] <= a_reg[2][i] * $signed(v_reg[2][i][VW-1:32]);
                pp3_reg[i] <= a_reg[2][i] * $signed({1'b0, v_reg[2][i][31:0]});
            end

            // Stage 4: join the halves of each axis product.
            ctx_reg[4] <= ctx_reg[3];
            a_reg[4]   <= a_reg[3];
            h_reg[4]   <= h_reg[3];
            v_reg[4]   <= v_reg[3];
            for (int i = 0; i < 3; i++)
            begin
                tc4_reg[i] <= (TW'(pl3_reg[i]) <<< 32) + TW'(pp3_reg[i]);
            end

            // Stage 5: axis parameter.
            ctx_reg[5] <= ctx_reg[4];
            a_reg[5]   <= a_reg[4];
            h_reg[5]   <= h_reg[4];
            v_reg[5]   <= v_reg[4];
            t5_reg     <= tc4_reg[0] + tc4_reg[1] + tc4_reg[2];

            // Stage 6: height range check and floor of the parameter.
            ctx_reg[6] <= ctx6_c;
            a_reg[6]   <= a_reg[5];
            v_reg[6]   <= v_reg[5];
            tq6_reg    <= t5_reg[2 * F + 1 +: 32];

            // Stage 7: axis point scaled by the parameter.
            ctx_reg[7] <= ctx_reg[6];
            v_reg[7]   <= v_reg[6];
            for (int i = 0; i < 3; i++)
            begin
                m7_reg[i] <= $signed(tq6_reg) * a_reg[6][i];
            end

            // Stage 8: radial vector, floored to the working fraction.
            ctx_reg[8] <= ctx_reg[7];
            for (int i = 0; i < 3; i++)
            begin
                rq8_reg[i] <= r_c[i][RW-1:F+1];
            end

            // Stage 9: magnitude split into halves for squaring.
            ctx_reg[9] <= ctx_reg[8];
            for (int i = 0; i < 3; i++)
            begin
                hi9_reg[i] <= mag_c[i][QRW-1:HLW];
                lo9_reg[i] <= mag_c[i][HLW-1:0];
            end

            // Stage 10: partial squares.
            ctx_reg[10] <= ctx_reg[9];
            for (int i = 0; i < 3; i++)
            begin
                hh10_reg[i] <= hi9_reg[i] * hi9_reg[i];
                hl10_reg[i] <= QRW'(hi9_reg[i]) * QRW'(lo9_reg[i]);
                ll10_reg[i] <= lo9_reg[i] * lo9_reg[i];
            end

            // Stage 11: full squares.
            ctx_reg[11] <= ctx_reg[10];
            for (int i = 0; i < 3; i++)
            begin
                sq11_reg[i] <= (SQW'(hh10_reg[i]) << (2 * HLW))
                             + (SQW'(hl10_reg[i]) << (HLW + 1))
                             + SQW'(ll10_reg[i]);
            end

            // Stage 12: squared radial distance.
            ctx_reg[12] <= ctx_reg[11];
            s12_reg     <= SSW'(sq11_reg[0]) + SSW'(sq11_reg[1]) + SSW'(sq11_reg[2]);

            // Stage 13: final verdict into the output register.
            if (ctx_reg[12].known && (ctx_reg[12].kind == pipt_pkg::KIND_CYLINDER))
            begin
                res_reg <= cyl_ok_c;
            end
            else
            begin
                res_reg <= ctx_reg[12].simple_ok;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/core/point_in_primitive_test.sv]
// Top level of the point-in-primitive test: front, queue and back pipeline.
// Depends on pipt_pkg, pipt_front, pipt_queue, pipt_back and assert_macros.svh.
//
//   channel | signals                                  | dir
//   --------+------------------------------------------+-----
//   cfg     | cfg_we, cfg_addr, cfg_wdata              | in
//   in      | in_valid/in_ready, func .. length        | in
//   out     | out_valid/out_ready, inside_res          | out
//
// One beat is accepted per cycle while the output is not stalled; its result
// passes the front holding register, the queue and then the thirteen back
// stages, whose split multipliers set the depth.
// Reset clears the query point to the origin and empties every stage.
// A stalled output freezes the back pipeline; the queue and front register
// keep accepting until they are full.
`default_nettype none
`include "assert_macros.svh"
module point_in_primitive_test #(
    parameter int FRAC_BITS = 16
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_we,
    input  wire  [1:0]         cfg_addr,
    input  wire  [31:0]        cfg_wdata,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire  [1:0]         func,
    input  wire  signed [31:0] anchor_x,
    input  wire  signed [31:0] anchor_y,
    input  wire  signed [31:0] anchor_z,
    input  wire  signed [31:0] dir_x,
    input  wire  signed [31:0] dir_y,
    input  wire  signed [31:0] dir_z,
    input  wire  [30:0]        diameter,
    input  wire  [30:0]        length,
    output logic               out_valid,
    input  wire                out_ready,
    output logic               inside_res
);

    logic              push_valid;
    logic              push_ready;
    pipt_pkg::qent_t   push_data;
    logic              pop_valid;
    logic              pop_ready;
    pipt_pkg::qent_t   pop_data;
    pipt_pkg::qstat_t  qstat;
    pipt_pkg::bstat_t  bstat;

    // Front: configuration and classification.
    pipt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .func       (func),
        .anchor_x   (anchor_x),
        .anchor_y   (anchor_y),
        .anchor_z   (anchor_z),
        .dir_x      (dir_x),
        .dir_y      (dir_y),
        .dir_z      (dir_z),
        .diameter   (diameter),
        .length     (length),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Queue between the two parts.
    pipt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .stat       (qstat)
    );

    // Back: arithmetic pipeline and output register.
    pipt_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (pop_valid),
        .q_ready    (pop_ready),
        .q_data     (pop_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .inside_res (inside_res),
        .stat       (bstat)
    );

    // A waiting result must freeze the pipeline.
    `ASSERT_IMP(a_stall_freezes, clk, rst_n, out_valid && !out_ready, !bstat.adv)
    // The queue never holds more than its depth.
    `ASSERT_IMP(a_queue_bound, clk, rst_n, 1'b1, qstat.count <= pipt_pkg::QCNT_W'(pipt_pkg::QUEUE_DEPTH))
    // No result appears unless an item was already in flight.
    `ASSERT_NXT(a_no_phantom, clk, rst_n, !bstat.busy && !out_valid, !out_valid)

endmodule
`default_nettype wire
